@@ hdl/mi_cdir_pkg.sv @@
// shared types and constants of the mi coherence directory
// no dependencies
`timescale 1ns / 1ps

package mi_cdir_pkg;

  // default sizes, taken as defaults by the top level parameters
  localparam int unsigned NODES_DEF  = 16;
  localparam int unsigned BLOCKS_DEF = 1024;

  // fixed field widths
  localparam int unsigned NODE_W   = 4;
  localparam int unsigned BLOCK_W  = 10;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned LAT_W    = 10;
  localparam int unsigned ACTIVE_W = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_NODES   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LATENCY = 4'd1;

  // directory block states
  localparam logic [1:0] ST_I  = 2'd0;
  localparam logic [1:0] ST_M  = 2'd1;
  localparam logic [1:0] ST_MM = 2'd2;

  // request message kinds
  localparam logic MSG_GETM = 1'b0;
  localparam logic MSG_DATA = 1'b1;

  // sent message kinds
  localparam logic SEND_DATA   = 1'b0;
  localparam logic SEND_RECALL = 1'b1;

  typedef enum logic [2:0] {
    QA_NONE     = 3'd0,
    QA_HELD     = 3'd1,
    QA_DEQUEUED = 3'd2,
    QA_ROTATED  = 3'd3,
    QA_ERROR    = 3'd4
  } qa_e;

  typedef struct packed {
    logic               op;
    logic [NODE_W-1:0]  src_node;
    logic [BLOCK_W-1:0] block_index;
    logic               msg_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]         queue_action;
    logic               send_valid;
    logic [NODE_W-1:0]  send_node;
    logic [BLOCK_W-1:0] send_block;
    logic               send_kind;
    logic               memory_read_pulse;
    logic               memory_write_pulse;
    logic               transfer_pulse;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hdl/mi_cdir_chan_if.sv @@
// valid/ready channel carrying one payload item
// depends on mi_cdir_pkg for the default payload type
`timescale 1ns / 1ps

interface mi_cdir_chan_if #(
  parameter type T = mi_cdir_pkg::req_t
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/mi_cdir_ctrl.sv @@
// sequencing controller: clearing pass, accept, read-modify-write step
// depends on mi_cdir_pkg for command and status types
`timescale 1ns / 1ps

module mi_cdir_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mi_cdir_pkg::dp_sts_t sts_i,
  output mi_cdir_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    CS_CLEAR = 3'b001,
    CS_IDLE  = 3'b010,
    CS_EXEC  = 3'b100
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      CS_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // wait here while the previous result still sits in the output register
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/mi_cdir_dpath.sv @@
// datapath: directory memory, fetch tracker, config registers, output register
// depends on mi_cdir_pkg for payload, command and status types
`timescale 1ns / 1ps

module mi_cdir_dpath #(
  parameter int unsigned NODES  = mi_cdir_pkg::NODES_DEF,
  parameter int unsigned BLOCKS = mi_cdir_pkg::BLOCKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mi_cdir_pkg::dp_cmd_t cmd_i,
  output mi_cdir_pkg::dp_sts_t sts_o,
  input  mi_cdir_pkg::req_t    req_i,
  input  logic                 cfg_valid_i,
  input  mi_cdir_pkg::cfg_t    cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mi_cdir_pkg::rsp_t    out_o
);

  localparam int unsigned NW  = mi_cdir_pkg::NODE_W;
  localparam int unsigned BW  = mi_cdir_pkg::BLOCK_W;
  localparam int unsigned CW  = mi_cdir_pkg::COUNT_W;
  localparam int unsigned TW  = mi_cdir_pkg::LAT_W;
  localparam int unsigned AVW = mi_cdir_pkg::ACTIVE_W;
  localparam int unsigned AW  = $clog2(BLOCKS);
  localparam int unsigned IW  = (AW > BW) ? AW : BW;
  localparam int unsigned LW  = $clog2(NODES + 1);

  // entry layout: state | presence | count | waiting requester
  localparam int unsigned WT_LSB   = 0;
  localparam int unsigned CNT_LSB  = WT_LSB + NW;
  localparam int unsigned PRES_LSB = CNT_LSB + CW;
  localparam int unsigned ST_LSB   = PRES_LSB + NODES;
  localparam int unsigned EW       = ST_LSB + 2;

  localparam logic [CW-1:0] CNT_MAX = '1;

  function automatic logic [NODES-1:0] node_mask(input logic [NW-1:0] node);
    logic [NODES-1:0] m;
    m = '0;
    for (int i = 0; i < NODES; i++) begin
      m[i] = (32'(node) == i);
    end
    return m;
  endfunction

  function automatic logic [CW-1:0] cnt_up(input logic [CW-1:0] c);
    return (c != CNT_MAX) ? c + CW'(1) : c;
  endfunction

  function automatic logic [CW-1:0] cnt_down(input logic [CW-1:0] c);
    return (c != '0) ? c - CW'(1) : c;
  endfunction

  // directory memory, no reset: the clearing pass writes every entry
  logic [EW-1:0] mem_q [BLOCKS];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_blk_ext;

  // request register and clear sweep counter
  mi_cdir_pkg::req_t req_q;
  logic [AW-1:0]     clr_addr_q;

  // configuration registers
  logic [AVW-1:0] active_q;
  logic [TW-1:0]  latency_q;

  // fetch tracker
  logic          fetch_busy_q, fetch_busy_d;
  logic [TW-1:0] fetch_cnt_q, fetch_cnt_d;
  logic [NW-1:0] fetch_node_q, fetch_node_d;
  logic [BW-1:0] fetch_block_q, fetch_block_d;

  // output register
  logic              out_valid_q;
  mi_cdir_pkg::rsp_t out_q;

  // step results
  mi_cdir_pkg::rsp_t rsp;
  logic              entry_we;
  logic [EW-1:0]     entry_new;
  logic [AW-1:0]     ex_addr;
  logic [IW-1:0]     ex_blk_ext;
  logic              in_range;
  logic [LW-1:0]     lim;
  logic [NW-1:0]     owner;

  // fields of the entry read for this item
  logic [1:0]       rd_state;
  logic [NODES-1:0] rd_pres;
  logic [CW-1:0]    rd_cnt;
  logic [NW-1:0]    rd_wait;
  logic [NODES-1:0] pres_new;
  logic [CW-1:0]    cnt_new;

  assign rd_state = rd_q[ST_LSB +: 2];
  assign rd_pres  = rd_q[PRES_LSB +: NODES];
  assign rd_cnt   = rd_q[CNT_LSB +: CW];
  assign rd_wait  = rd_q[WT_LSB +: NW];

  assign rd_blk_ext = IW'(req_i.block_index);
  assign rd_addr    = rd_blk_ext[AW-1:0];
  assign ex_blk_ext = IW'(req_q.block_index);
  assign ex_addr    = ex_blk_ext[AW-1:0];
  assign in_range   = (32'(req_q.block_index) < 32'(BLOCKS));

  // scan limit for the owner search
  assign lim = (32'(active_q) > 32'(NODES)) ? LW'(NODES) : LW'(active_q);

  // highest present node below the limit, all-ones when none
  always_comb begin
    owner = '1;
    for (int i = 0; i < NODES; i++) begin
      if (rd_pres[i] && (i < 32'(lim))) begin
        owner = NW'(i);
      end
    end
  end

  // directory step and fetch countdown for one item
  always_comb begin
    logic          busy_m;
    logic [TW-1:0] cnt_m;
    rsp           = '0;
    entry_we      = 1'b0;
    pres_new      = rd_pres;
    cnt_new       = rd_cnt;
    entry_new     = rd_q;
    busy_m        = fetch_busy_q;
    cnt_m         = fetch_cnt_q;
    fetch_node_d  = fetch_node_q;
    fetch_block_d = fetch_block_q;
    rsp.queue_action = mi_cdir_pkg::QA_NONE;

    if (req_q.op) begin
      if (fetch_busy_q) begin
        rsp.queue_action = mi_cdir_pkg::QA_HELD;
      end else if (!in_range) begin
        rsp.queue_action = mi_cdir_pkg::QA_ERROR;
      end else if (rd_state == mi_cdir_pkg::ST_I && req_q.msg_kind == mi_cdir_pkg::MSG_GETM)
      begin
        // start the memory fetch
        busy_m        = 1'b1;
        cnt_m         = latency_q;
        fetch_node_d  = req_q.src_node;
        fetch_block_d = req_q.block_index;
        pres_new      = rd_pres | node_mask(req_q.src_node);
        cnt_new       = cnt_up(rd_cnt);
        entry_new[ST_LSB +: 2] = mi_cdir_pkg::ST_M;
        entry_we      = 1'b1;
        rsp.queue_action = mi_cdir_pkg::QA_DEQUEUED;
      end else if (rd_state == mi_cdir_pkg::ST_M && req_q.msg_kind == mi_cdir_pkg::MSG_GETM)
      begin
        // recall the owner
        rsp.send_valid = 1'b1;
        rsp.send_node  = owner;
        rsp.send_block = req_q.block_index;
        rsp.send_kind  = mi_cdir_pkg::SEND_RECALL;
        entry_new[ST_LSB +: 2] = mi_cdir_pkg::ST_MM;
        entry_new[WT_LSB +: NW] = req_q.src_node;
        entry_we       = 1'b1;
        rsp.queue_action = mi_cdir_pkg::QA_DEQUEUED;
      end else if (rd_state == mi_cdir_pkg::ST_MM && req_q.msg_kind == mi_cdir_pkg::MSG_DATA)
      begin
        // owner writeback, forward to the waiting requester
        pres_new = (rd_pres & ~node_mask(req_q.src_node)) | node_mask(rd_wait);
        cnt_new  = cnt_up(cnt_down(rd_cnt));
        rsp.transfer_pulse     = 1'b1;
        rsp.memory_write_pulse = 1'b1;
        rsp.send_valid = 1'b1;
        rsp.send_node  = rd_wait;
        rsp.send_block = req_q.block_index;
        rsp.send_kind  = mi_cdir_pkg::SEND_DATA;
        entry_new[ST_LSB +: 2] = mi_cdir_pkg::ST_M;
        entry_we       = 1'b1;
        rsp.queue_action = mi_cdir_pkg::QA_DEQUEUED;
      end else if (rd_state == mi_cdir_pkg::ST_MM && req_q.msg_kind == mi_cdir_pkg::MSG_GETM)
      begin
        rsp.queue_action = mi_cdir_pkg::QA_ROTATED;
      end else begin
        rsp.queue_action = mi_cdir_pkg::QA_ERROR;
      end
    end

    entry_new[PRES_LSB +: NODES] = pres_new;
    entry_new[CNT_LSB +: CW]     = cnt_new;

    // fetch completion, also in the item that starts it
    fetch_busy_d = busy_m;
    fetch_cnt_d  = cnt_m;
    if (busy_m) begin
      if (cnt_m == '0) begin
        rsp.memory_read_pulse = 1'b1;
        rsp.send_valid = 1'b1;
        rsp.send_node  = fetch_node_d;
        rsp.send_block = fetch_block_d;
        rsp.send_kind  = mi_cdir_pkg::SEND_DATA;
        fetch_busy_d   = 1'b0;
      end else begin
        fetch_cnt_d = cnt_m - TW'(1);
      end
    end
  end

  // memory write port: clearing pass or the step's write back
  assign mem_we    = cmd_i.clear | (cmd_i.exec & entry_we);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : ex_addr;
  assign mem_wdata = cmd_i.clear ? '0 : entry_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
  end

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_addr_q == AW'(BLOCKS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= AVW'(16);
      latency_q <= TW'(100);
    end else if (cfg_valid_i) begin
      if (cfg_i.index == mi_cdir_pkg::CFG_ACTIVE_NODES) begin
        active_q <= cfg_i.value[AVW-1:0];
      end else if (cfg_i.index == mi_cdir_pkg::CFG_MEMORY_LATENCY) begin
        latency_q <= cfg_i.value[TW-1:0];
      end
    end
  end

  // fetch tracker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_busy_q  <= 1'b0;
      fetch_cnt_q   <= '0;
      fetch_node_q  <= '0;
      fetch_block_q <= '0;
    end else if (cmd_i.exec) begin
      fetch_busy_q  <= fetch_busy_d;
      fetch_cnt_q   <= fetch_cnt_d;
      fetch_node_q  <= fetch_node_d;
      fetch_block_q <= fetch_block_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ hdl/mi_coherence_directory_top.sv @@
// top level of the mi coherence directory: controller plus datapath
// depends on mi_cdir_pkg, mi_cdir_chan_if, mi_cdir_ctrl, mi_cdir_dpath
// the result enters the output register in the exec step that follows its acceptance,
// later while an older result still waits there to be taken
// a new item is taken only once the last one has done its directory read then write
// the output register lets the next item in while a result waits to be taken
// reset: a clearing pass writes every directory entry to I,
// items are held off until it ends, config writes are taken at any time
`timescale 1ns / 1ps

module mi_coherence_directory_top #(
  parameter int unsigned NODES  = mi_cdir_pkg::NODES_DEF,
  parameter int unsigned BLOCKS = mi_cdir_pkg::BLOCKS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mi_cdir_chan_if.sink   in_i,
  mi_cdir_chan_if.source out_o,
  mi_cdir_chan_if.sink   cfg_i
);

  mi_cdir_pkg::dp_cmd_t cmd;
  mi_cdir_pkg::dp_sts_t sts;

  // config writes always taken
  assign cfg_i.ready = 1'b1;

  mi_cdir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mi_cdir_dpath #(
    .NODES  (NODES),
    .BLOCKS (BLOCKS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_o.data)
  );

  // an accepted item blocks the input for the following cycle
  a_two_cycle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  // a writeback always comes with a forwarded data message
  a_writeback_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.memory_write_pulse) |->
      (out_o.data.transfer_pulse && out_o.data.send_valid &&
       out_o.data.send_kind == mi_cdir_pkg::SEND_DATA))
    else $error("writeback without forwarded data");

  // fetch delivery and writeback never share an item
  a_read_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.memory_read_pulse && out_o.data.memory_write_pulse))
    else $error("fetch delivery and writeback in one item");

  // send fields are zero when nothing is sent
  a_send_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.send_valid) |->
      (out_o.data.send_node == '0 && out_o.data.send_block == '0 &&
       out_o.data.send_kind == 1'b0))
    else $error("send fields not zero without a message");

endmodule
